// ===== rtl/rpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_HIT     = 2'd1;
   localparam logic [1:0] KIND_TRAILER = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_HEADER_FLAG  = 3'd1;
   localparam logic [2:0] ERR_TRAILER_FLAG = 3'd2;
   localparam logic [2:0] ERR_TRIGGER      = 3'd3;
   localparam logic [2:0] ERR_SEQ_FLAG     = 3'd4;

   localparam logic [2:0] HEADER_FLAG  = 3'd6;
   localparam logic [2:0] TRAILER_FLAG = 3'd7;
   localparam logic [3:0] SEQ_FLAG     = 4'd4;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [2:0]  error_code;
      logic [2:0]  status_or_chip;
      logic [31:0] count_or_frame;
      logic [7:0]  hits_or_channel;
      logic [17:0] time_or_last_count;
      logic [53:0] payload;
      logic [4:0]  board_id;
      logic [4:0]  seq_board_id;
      logic [15:0] packet_index;
   } record_type;

   typedef struct packed {
      logic emit;
      logic halted;
   } parse_status_type;

endpackage

`default_nettype wire

// ===== rtl/rpd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rpd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface rpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [2:0]  error_code;
   logic [2:0]  status_or_chip;
   logic [31:0] count_or_frame;
   logic [7:0]  hits_or_channel;
   logic [17:0] time_or_last_count;
   logic [53:0] payload;
   logic [4:0]  board_id;
   logic [4:0]  seq_board_id;
   logic [15:0] packet_index;

   modport source (
      output valid, output record_kind, output error_code, output status_or_chip,
      output count_or_frame, output hits_or_channel, output time_or_last_count,
      output payload, output board_id, output seq_board_id, output packet_index,
      input ready
   );
   modport sink (
      input valid, input record_kind, input error_code, input status_or_chip,
      input count_or_frame, input hits_or_channel, input time_or_last_count,
      input payload, input board_id, input seq_board_id, input packet_index,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/readout_packet_deframer.sv =====
// Readout packet deframer.
//
// req_chan carries one 32-bit packet word per transaction, first byte in the
// most significant bits. rsp_chan carries one record per transaction: header,
// hit, trailer or error, each with the fields of its kind and zero elsewhere.
// Records stream out as soon as the word that completes them arrives.
//
// An accepted word is held in an input register, decoded by the packet parser
// against its saved state, and any record it completes is written to a
// two-entry output queue. A record is therefore presented once its last word
// has passed the input register and been written to the queue. One word is
// taken every cycle as long as the queue has room; the queue depth of two lets
// a record wait for the receiver while the next word is still accepted.
//
// When the receiver stalls, the queue fills and req_chan.ready falls once the
// input register cannot move on; nothing is dropped. After an error record the
// parser halts: further words are accepted and discarded until reset.
// Reset (synchronous, active high) empties the queue and returns the parser to
// waiting for the first header word with a packet count of zero.
`timescale 1ns / 1ps
`default_nettype none

module readout_packet_deframer (
   input  wire        clock,
   input  wire        reset,
   rpd_req_if.sink    req_chan,
   rpd_rsp_if.source  rsp_chan
);

   logic                       in_valid_ff, in_valid_in;
   logic [31:0]                in_word_ff;
   logic                       step;
   logic                       queue_not_full;
   logic                       queue_not_empty;
   logic [1:0]                 queue_fill;
   rpd_pkg::record_type        parse_rec;
   rpd_pkg::record_type        head_rec;
   rpd_pkg::parse_status_type  parse_status;

   // The held word moves on whenever the queue can take a record.
   assign step           = in_valid_ff && queue_not_full;
   assign req_chan.ready = !in_valid_ff || queue_not_full;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_word_ff <= req_chan.word;
      end
   end

   rpd_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_word_ff),
      .rec    (parse_rec),
      .status (parse_status)
   );

   rpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step && parse_status.emit),
      .push_rec  (parse_rec),
      .not_full  (queue_not_full),
      .pop       (rsp_chan.ready),
      .not_empty (queue_not_empty),
      .head_rec  (head_rec),
      .fill      (queue_fill)
   );

   assign rsp_chan.valid              = queue_not_empty;
   assign rsp_chan.record_kind        = head_rec.record_kind;
   assign rsp_chan.error_code         = head_rec.error_code;
   assign rsp_chan.status_or_chip     = head_rec.status_or_chip;
   assign rsp_chan.count_or_frame     = head_rec.count_or_frame;
   assign rsp_chan.hits_or_channel    = head_rec.hits_or_channel;
   assign rsp_chan.time_or_last_count = head_rec.time_or_last_count;
   assign rsp_chan.payload            = head_rec.payload;
   assign rsp_chan.board_id           = head_rec.board_id;
   assign rsp_chan.seq_board_id       = head_rec.seq_board_id;
   assign rsp_chan.packet_index       = head_rec.packet_index;

   // A halted parser never produces another record.
   a_no_emit_when_halted : assert property (@(posedge clock) disable iff (reset)
      !(parse_status.halted && parse_status.emit))
      else $error("record produced while halted");

   // The halt is only left through reset.
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      parse_status.halted |=> parse_status.halted)
      else $error("halt cleared without reset");

   // Error records and only error records carry an error code.
   a_error_code : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((rsp_chan.record_kind == rpd_pkg::KIND_ERROR) ==
          (rsp_chan.error_code != rpd_pkg::ERR_NONE)))
      else $error("error code does not match record kind");

   // The output queue never holds more than its two entries.
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      queue_fill != 2'd3)
      else $error("output queue overfilled");

endmodule

`default_nettype wire

// ===== rtl/rpd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpd_parse (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          step,
   input  wire [31:0]                   word,
   output rpd_pkg::record_type          rec,
   output rpd_pkg::parse_status_type    status
);

   localparam logic [2:0] PH_HEAD0 = 3'd0;
   localparam logic [2:0] PH_HEAD1 = 3'd1;
   localparam logic [2:0] PH_DATA0 = 3'd2;
   localparam logic [2:0] PH_DATA1 = 3'd3;
   localparam logic [2:0] PH_TRL0  = 3'd4;
   localparam logic [2:0] PH_TRL1  = 3'd5;
   localparam logic [2:0] PH_SEQ0  = 3'd6;
   localparam logic [2:0] PH_SEQ1  = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [7:0]  hits_left_ff, hits_left_in;
   logic [28:0] header_saved_ff, header_saved_in;
   logic [2:0]  trigger_low_ff, trigger_low_in;
   logic [29:0] hit_saved_ff, hit_saved_in;
   logic [28:0] trailer_first_ff, trailer_first_in;
   logic [26:0] trailer_second_ff, trailer_second_in;
   logic [24:0] sequence_first_ff, sequence_first_in;
   logic [15:0] packet_counter_ff, packet_counter_in;
   logic        emit;
   logic        fail;
   logic [2:0]  fail_code;

   always_comb begin
      phase_in          = phase_ff;
      halted_in         = halted_ff;
      hits_left_in      = hits_left_ff;
      header_saved_in   = header_saved_ff;
      trigger_low_in    = trigger_low_ff;
      hit_saved_in      = hit_saved_ff;
      trailer_first_in  = trailer_first_ff;
      trailer_second_in = trailer_second_ff;
      sequence_first_in = sequence_first_ff;
      packet_counter_in = packet_counter_ff;
      emit              = 1'b0;
      fail              = 1'b0;
      fail_code         = rpd_pkg::ERR_NONE;
      rec               = '0;
      rec.packet_index  = packet_counter_ff;

      case (phase_ff)
         PH_HEAD0: begin
            if (word[31:29] != rpd_pkg::HEADER_FLAG) begin
               fail      = 1'b1;
               fail_code = rpd_pkg::ERR_HEADER_FLAG;
            end else begin
               header_saved_in = word[28:0];
               phase_in        = PH_HEAD1;
            end
         end
         PH_HEAD1: begin
            emit                   = 1'b1;
            rec.record_kind        = rpd_pkg::KIND_HEADER;
            rec.status_or_chip     = header_saved_ff[28:26];
            rec.count_or_frame     = {header_saved_ff[25:0], word[29:24]};
            rec.hits_or_channel    = word[23:16];
            rec.time_or_last_count = {2'b00, word[15:0]};
            trigger_low_in         = word[26:24];
            hits_left_in           = word[23:16];
            phase_in               = (word[23:16] != 8'd0) ? PH_DATA0 : PH_TRL0;
         end
         PH_DATA0: begin
            hit_saved_in = word[29:0];
            phase_in     = PH_DATA1;
         end
         PH_DATA1: begin
            emit               = 1'b1;
            rec.record_kind    = rpd_pkg::KIND_HIT;
            rec.status_or_chip = hit_saved_ff[29:27];
            rec.count_or_frame = {29'd0, hit_saved_ff[26:24]};
            rec.payload        = {hit_saved_ff[23:0], word[29:0]};
            hits_left_in       = hits_left_ff - 8'd1;
            // The last pair is the one that brings the count from one to zero.
            phase_in           = (hits_left_ff != 8'd1) ? PH_DATA0 : PH_TRL0;
         end
         PH_TRL0: begin
            if (word[31:29] != rpd_pkg::TRAILER_FLAG) begin
               fail      = 1'b1;
               fail_code = rpd_pkg::ERR_TRAILER_FLAG;
            end else begin
               trailer_first_in = word[28:0];
               phase_in         = PH_TRL1;
            end
         end
         PH_TRL1: begin
            if (word[26:24] != trigger_low_ff) begin
               fail      = 1'b1;
               fail_code = rpd_pkg::ERR_TRIGGER;
            end else begin
               trailer_second_in = {word[29:27], word[23:0]};
               phase_in          = PH_SEQ0;
            end
         end
         PH_SEQ0: begin
            if (word[31:28] != rpd_pkg::SEQ_FLAG) begin
               fail      = 1'b1;
               fail_code = rpd_pkg::ERR_SEQ_FLAG;
            end else begin
               sequence_first_in = word[24:0];
               phase_in          = PH_SEQ1;
            end
         end
         PH_SEQ1: begin
            if (word[31:28] != rpd_pkg::SEQ_FLAG) begin
               fail      = 1'b1;
               fail_code = rpd_pkg::ERR_SEQ_FLAG;
            end else begin
               emit                   = 1'b1;
               rec.record_kind        = rpd_pkg::KIND_TRAILER;
               rec.status_or_chip     = trailer_second_ff[26:24];
               rec.count_or_frame     = {8'd0, trailer_first_ff[28:5]};
               rec.hits_or_channel    = {2'b00, trailer_second_ff[23:18]};
               rec.time_or_last_count = trailer_second_ff[17:0];
               rec.payload            = {6'd0, sequence_first_ff[19:0], word[27:0]};
               rec.board_id           = trailer_first_ff[4:0];
               rec.seq_board_id       = sequence_first_ff[24:20];
               packet_counter_in      = packet_counter_ff + 16'd1;
               phase_in               = PH_HEAD0;
            end
         end
         default: begin
            phase_in = PH_HEAD0;
         end
      endcase

      // An error record carries only its kind, its code and the packet index.
      if (fail) begin
         emit             = 1'b1;
         halted_in        = 1'b1;
         rec              = '0;
         rec.record_kind  = rpd_pkg::KIND_ERROR;
         rec.error_code   = fail_code;
         rec.packet_index = packet_counter_ff;
      end

      // Once halted, words are consumed and dropped until reset.
      if (halted_ff) begin
         emit              = 1'b0;
         phase_in          = phase_ff;
         halted_in         = 1'b1;
         hits_left_in      = hits_left_ff;
         header_saved_in   = header_saved_ff;
         trigger_low_in    = trigger_low_ff;
         hit_saved_in      = hit_saved_ff;
         trailer_first_in  = trailer_first_ff;
         trailer_second_in = trailer_second_ff;
         sequence_first_in = sequence_first_ff;
         packet_counter_in = packet_counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEAD0;
         halted_ff         <= 1'b0;
         hits_left_ff      <= '0;
         header_saved_ff   <= '0;
         trigger_low_ff    <= '0;
         hit_saved_ff      <= '0;
         trailer_first_ff  <= '0;
         trailer_second_ff <= '0;
         sequence_first_ff <= '0;
         packet_counter_ff <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         halted_ff         <= halted_in;
         hits_left_ff      <= hits_left_in;
         header_saved_ff   <= header_saved_in;
         trigger_low_ff    <= trigger_low_in;
         hit_saved_ff      <= hit_saved_in;
         trailer_first_ff  <= trailer_first_in;
         trailer_second_ff <= trailer_second_in;
         sequence_first_ff <= sequence_first_in;
         packet_counter_ff <= packet_counter_in;
      end
   end

   assign status.emit   = emit;
   assign status.halted = halted_ff;

endmodule

`default_nettype wire

// ===== rtl/rpd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpd_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire rpd_pkg::record_type push_rec,
   output logic                  not_full,
   input  wire                   pop,
   output logic                  not_empty,
   output rpd_pkg::record_type   head_rec,
   output logic [1:0]            fill
);

   rpd_pkg::record_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire
